[rtl/lnpi_pkg.sv]
// Shared types, constants and codes for the line-number program interpreter.
// Used by lnpi_front, lnpi_cmd_queue, lnpi_back and the top level.
package lnpi_pkg;

  localparam int DEF_TABLE_ENTRIES = 16;
  localparam int DEF_COUNT_BITS    = 4;
  localparam int DEF_ADDRESS_BYTES = 8;
  localparam int CMDQ_DEPTH        = 4;

  // Configuration register indexes
  localparam logic [2:0] REG_OPCODE_BASE     = 3'd0;
  localparam logic [2:0] REG_LINE_BASE       = 3'd1;
  localparam logic [2:0] REG_LINE_RANGE      = 3'd2;
  localparam logic [2:0] REG_MIN_INST_LENGTH = 3'd3;
  localparam logic [2:0] REG_DEFAULT_IS_STMT = 3'd4;
  localparam logic [2:0] REG_ARG_COUNT_TABLE = 3'd5;

  // Configuration reset values
  localparam logic [4:0]  RST_OPCODE_BASE     = 5'd13;
  localparam logic [7:0]  RST_LINE_BASE       = 8'hFB;
  localparam logic [7:0]  RST_LINE_RANGE      = 8'd14;
  localparam logic [7:0]  RST_MIN_INST_LENGTH = 8'd1;
  localparam logic        RST_DEFAULT_IS_STMT = 1'b1;
  localparam logic [63:0] RST_ARG_COUNT_TABLE = 64'd17596481081616;

  // Standard opcodes
  localparam logic [7:0] OP_EXTENDED      = 8'd0;
  localparam logic [7:0] OP_COPY          = 8'd1;
  localparam logic [7:0] OP_ADVANCE_PC    = 8'd2;
  localparam logic [7:0] OP_ADVANCE_LINE  = 8'd3;
  localparam logic [7:0] OP_SET_FILE      = 8'd4;
  localparam logic [7:0] OP_SET_COLUMN    = 8'd5;
  localparam logic [7:0] OP_NEGATE_STMT   = 8'd6;
  localparam logic [7:0] OP_BASIC_BLOCK   = 8'd7;
  localparam logic [7:0] OP_CONST_ADD_PC  = 8'd8;
  localparam logic [7:0] OP_FIXED_ADV_PC  = 8'd9;
  localparam logic [7:0] OP_PROLOGUE_END  = 8'd10;
  localparam logic [7:0] OP_EPILOGUE_BEG  = 8'd11;
  localparam logic [7:0] OP_SET_ISA       = 8'd12;

  // Extended sub-opcodes
  localparam logic [7:0] EXT_END_SEQUENCE  = 8'd1;
  localparam logic [7:0] EXT_SET_ADDRESS   = 8'd2;
  localparam logic [7:0] EXT_DISCRIMINATOR = 8'd4;

  localparam logic [7:0] SPECIAL_LIMIT = 8'd255;

  typedef enum logic [2:0] {
    PH_IDLE, PH_FIX_LO, PH_FIX_HI, PH_STD_ARG, PH_EXT_LEN, PH_EXT_OP, PH_EXT_ARG
  } phase_t;

  typedef enum logic [1:0] {
    B_IDLE, B_DIV, B_MUL, B_EXEC
  } back_state_t;

  typedef enum logic [2:0] {
    CMD_NOP, CMD_SPECIAL, CMD_STD, CMD_FIX, CMD_EXT
  } cmd_kind_t;

  typedef struct packed {
    logic        init;   // reinitialize rows before the action
    cmd_kind_t   kind;
    logic [7:0]  op;
    logic        first;  // apply first operand of a standard opcode
    logic        final_; // apply closing action of a standard opcode
    logic [63:0] val;
  } cmd_t;

  typedef struct packed {
    logic [4:0]        opcode_base;
    logic signed [7:0] line_floor;
    logic [7:0]        line_span;
    logic [7:0]        min_inst_length;
    logic              stmt_init;
    logic [63:0]       arg_count_table;
  } cfg_t;

  typedef struct packed {
    logic [63:0] address;
    logic [31:0] file;
    logic [31:0] line;
    logic [31:0] column;
    logic        is_stmt;
    logic        block_start;
    logic        seq_end;
    logic        pro_end;
    logic        epi_start;
    logic [31:0] isa;
    logic [31:0] discriminator;
  } row_t;

endpackage

[rtl/lnpi_front.sv]
// Front end: byte parser that decodes opcodes and operands into commands.
// Depends on lnpi_pkg.
module lnpi_front #(
  parameter int TABLE_ENTRIES = lnpi_pkg::DEF_TABLE_ENTRIES,
  parameter int COUNT_BITS    = lnpi_pkg::DEF_COUNT_BITS,
  parameter int ADDRESS_BYTES = lnpi_pkg::DEF_ADDRESS_BYTES
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            take,
  input  logic [7:0]      data_byte,
  input  logic            new_program,
  input  lnpi_pkg::cfg_t  cfg,
  output logic            cmd_valid,
  output lnpi_pkg::cmd_t  cmd
);
  import lnpi_pkg::*;

  localparam int ADDR_BITS = ADDRESS_BYTES * 8;

  phase_t      phase, phase_next, ph_e;
  logic [7:0]  op, op_next;
  logic [63:0] acc, acc_next;
  logic [6:0]  shift, shift_next;
  logic [31:0] left, left_next;
  logic        first, first_next;

  logic [63:0] leb_acc, leb_sx, ext_n;
  logic [6:0]  leb_shift;
  logic        leb_end, special;
  logic [7:0]  idx;
  logic [COUNT_BITS-1:0] cnt;

  assign ph_e      = new_program ? PH_IDLE : phase;
  assign special   = data_byte >= {3'b0, cfg.opcode_base};
  assign leb_acc   = shift[6] ? acc : acc | ({57'b0, data_byte[6:0]} << shift[5:0]);
  assign leb_shift = shift[6] ? shift : shift + 7'd7;
  assign leb_end   = !data_byte[7];
  assign leb_sx    = (data_byte[6] && !leb_shift[6]) ?
                     leb_acc | (~64'b0 << leb_shift[5:0]) : leb_acc;
  assign ext_n     = leb_acc - 64'd1;
  assign idx       = data_byte - 8'd1;

  // Operand count lookup
  always_comb begin
    cnt = '0;
    for (int k = 0; k < TABLE_ENTRIES; k++) begin
      if (k * COUNT_BITS < 64 && idx == 8'(k) && data_byte != 8'd0)
        cnt = cfg.arg_count_table[k*COUNT_BITS +: COUNT_BITS];
    end
  end

  // Next state of the parser; new_program only counts with an accepted byte
  always_comb begin
    phase_next = phase;
    op_next    = op;
    acc_next   = acc;
    shift_next = shift;
    left_next  = left;
    first_next = first;
    if (take) begin
      phase_next = ph_e;
      unique case (ph_e)
        PH_IDLE: begin
          if (!special) begin
            op_next    = data_byte;
            acc_next   = '0;
            shift_next = '0;
            if (data_byte == OP_EXTENDED) begin
              phase_next = PH_EXT_LEN;
            end else if (data_byte == OP_FIXED_ADV_PC) begin
              phase_next = PH_FIX_LO;
            end else if (cnt != '0) begin
              left_next  = 32'(cnt);
              first_next = 1'b1;
              phase_next = PH_STD_ARG;
            end
          end
        end
        PH_FIX_LO: begin
          acc_next   = {56'b0, data_byte};
          phase_next = PH_FIX_HI;
        end
        PH_FIX_HI: phase_next = PH_IDLE;
        PH_STD_ARG: begin
          if (!leb_end) begin
            acc_next   = leb_acc;
            shift_next = leb_shift;
          end else begin
            first_next = 1'b0;
            acc_next   = '0;
            shift_next = '0;
            left_next  = left - 32'd1;
            if (left == 32'd1) phase_next = PH_IDLE;
          end
        end
        PH_EXT_LEN: begin
          if (!leb_end) begin
            acc_next   = leb_acc;
            shift_next = leb_shift;
          end else begin
            acc_next   = '0;
            shift_next = '0;
            if (leb_acc == 64'd0) begin
              phase_next = PH_IDLE;
            end else begin
              left_next  = (|ext_n[63:32]) ? 32'hFFFF_FFFF : ext_n[31:0];
              phase_next = PH_EXT_OP;
            end
          end
        end
        PH_EXT_OP: begin
          op_next    = data_byte;
          acc_next   = '0;
          shift_next = '0;
          first_next = 1'b1;
          phase_next = (left == 32'd0) ? PH_IDLE : PH_EXT_ARG;
        end
        PH_EXT_ARG: begin
          if (op == EXT_SET_ADDRESS) begin
            if (shift < 7'(ADDR_BITS) && !shift[6]) begin
              acc_next   = acc | ({56'b0, data_byte} << shift[5:0]);
              shift_next = shift + 7'd8;
            end
          end else if (op == EXT_DISCRIMINATOR && first) begin
            acc_next   = leb_acc;
            shift_next = leb_shift;
            if (leb_end) first_next = 1'b0;
          end
          left_next = left - 32'd1;
          if (left == 32'd1) phase_next = PH_IDLE;
        end
        default: begin
          phase_next = PH_IDLE;
          acc_next   = '0;
          shift_next = '0;
        end
      endcase
    end
  end

  // Command output
  always_comb begin
    cmd      = '0;
    cmd.kind = CMD_NOP;
    cmd.init = new_program;
    unique case (ph_e)
      PH_IDLE: begin
        if (special) begin
          cmd.kind = CMD_SPECIAL;
          cmd.val  = {56'b0, data_byte - {3'b0, cfg.opcode_base}};
        end else if (data_byte != OP_EXTENDED && data_byte != OP_FIXED_ADV_PC &&
                     cnt == '0) begin
          cmd.kind   = CMD_STD;
          cmd.op     = data_byte;
          cmd.final_ = 1'b1;
        end
      end
      PH_FIX_HI: begin
        cmd.kind = CMD_FIX;
        cmd.val  = {48'b0, data_byte, acc[7:0]};
      end
      PH_STD_ARG: begin
        if (leb_end && (first || left == 32'd1)) begin
          cmd.kind   = CMD_STD;
          cmd.op     = op;
          cmd.first  = first;
          cmd.val    = leb_sx;
          cmd.final_ = (left == 32'd1);
        end
      end
      PH_EXT_OP: begin
        if (left == 32'd0) begin
          cmd.kind = CMD_EXT;
          cmd.op   = data_byte;
        end
      end
      PH_EXT_ARG: begin
        if (left == 32'd1) begin
          cmd.kind = CMD_EXT;
          cmd.op   = op;
          cmd.val  = acc_next;
        end
      end
      default: cmd.kind = CMD_NOP;
    endcase
    cmd_valid = take && (new_program || cmd.kind != CMD_NOP);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      op    <= '0;
      acc   <= '0;
      shift <= '0;
      left  <= '0;
      first <= 1'b0;
    end else begin
      phase <= phase_next;
      op    <= op_next;
      acc   <= acc_next;
      shift <= shift_next;
      left  <= left_next;
      first <= first_next;
    end
  end

endmodule

[rtl/lnpi_cmd_queue.sv]
// Short command queue between the parser and the row engine.
// Depends on lnpi_pkg.
module lnpi_cmd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_valid,
  input  lnpi_pkg::cmd_t wr_cmd,
  input  logic           rd_en,
  output lnpi_pkg::cmd_t rd_cmd,
  output logic           empty,
  output logic           full
);
  import lnpi_pkg::*;

  localparam int PW = $clog2(CMDQ_DEPTH);
  localparam int CW = $clog2(CMDQ_DEPTH + 1);

  cmd_t          slots [CMDQ_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr, do_rd;

  assign empty  = (count == '0);
  assign full   = (count == CW'(CMDQ_DEPTH));
  assign do_wr  = wr_valid && !full;
  assign do_rd  = rd_en && !empty;
  assign rd_cmd = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) slots[wr_ptr] <= wr_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= (wr_ptr == PW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= (rd_ptr == PW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_wr && !do_rd)      count <= count + 1'b1;
      else if (do_rd && !do_wr) count <= count - 1'b1;
    end
  end

endmodule

[rtl/lnpi_back.sv]
// Back end: row engine with serial divider, address multiplier and row output register.
// Depends on lnpi_pkg.
module lnpi_back (
  input  logic           clk,
  input  logic           rst,
  input  lnpi_pkg::cfg_t cfg,
  input  logic           q_empty,
  input  lnpi_pkg::cmd_t q_cmd,
  output logic           q_pop,
  output lnpi_pkg::row_t out_row,
  output logic           out_valid,
  input  logic           out_pop
);
  import lnpi_pkg::*;

  back_state_t state, state_next;
  cmd_t        cur;
  row_t        row, row_n, row_after, init_row;
  logic [7:0]  div_r, div_q, dv, div_r_n, div_q_n;
  logic [8:0]  trial;
  logic [2:0]  div_cnt;
  logic [63:0] prod, mul_a;
  logic [71:0] mprod;
  logic        emit, can_emit, needs_div, needs_mul;

  assign can_emit  = !out_valid || out_pop;
  assign dv        = (cfg.line_span == 8'd0) ? 8'd1 : cfg.line_span;
  assign trial     = {div_r, div_q[7]};
  assign div_r_n   = (trial >= {1'b0, dv}) ? 8'(trial - {1'b0, dv}) : trial[7:0];
  assign div_q_n   = {div_q[6:0], trial >= {1'b0, dv}};
  assign mul_a     = (cur.kind == CMD_STD && cur.first && cur.op == OP_ADVANCE_PC) ?
                     cur.val : {56'b0, div_q};
  assign mprod     = mul_a * cfg.min_inst_length;
  assign needs_div = q_cmd.kind == CMD_SPECIAL ||
                     (q_cmd.kind == CMD_STD && q_cmd.final_ && q_cmd.op == OP_CONST_ADD_PC);
  assign needs_mul = q_cmd.kind == CMD_STD && q_cmd.first && q_cmd.op == OP_ADVANCE_PC;
  assign q_pop     = (state == B_IDLE) && !q_empty;

  always_comb begin
    init_row         = '0;
    init_row.file    = 32'd1;
    init_row.line    = 32'd1;
    init_row.is_stmt = cfg.stmt_init;
  end

  // Row update for the command in hand
  always_comb begin
    row_n = row;
    emit  = 1'b0;
    case (cur.kind)
      CMD_SPECIAL: begin
        row_n.line    = row.line + 32'(cfg.line_floor) + {24'b0, div_r};
        row_n.address = row.address + prod;
        emit          = 1'b1;
      end
      CMD_STD: begin
        if (cur.first) begin
          case (cur.op)
            OP_ADVANCE_PC:   row_n.address = row.address + prod;
            OP_ADVANCE_LINE: row_n.line    = row.line + cur.val[31:0];
            OP_SET_FILE:     row_n.file    = cur.val[31:0];
            OP_SET_COLUMN:   row_n.column  = cur.val[31:0];
            OP_SET_ISA:      row_n.isa     = cur.val[31:0];
            default: ;
          endcase
        end
        if (cur.final_) begin
          case (cur.op)
            OP_COPY:         emit              = 1'b1;
            OP_NEGATE_STMT:  row_n.is_stmt     = !row.is_stmt;
            OP_BASIC_BLOCK:  row_n.block_start = 1'b1;
            OP_CONST_ADD_PC: row_n.address     = row.address + prod;
            OP_PROLOGUE_END: row_n.pro_end     = 1'b1;
            OP_EPILOGUE_BEG: row_n.epi_start   = 1'b1;
            default: ;
          endcase
        end
      end
      CMD_FIX: row_n.address = row.address + {48'b0, cur.val[15:0]};
      CMD_EXT: begin
        case (cur.op)
          EXT_END_SEQUENCE: begin
            row_n.seq_end = 1'b1;
            emit          = 1'b1;
          end
          EXT_SET_ADDRESS:   row_n.address       = cur.val;
          EXT_DISCRIMINATOR: row_n.discriminator = cur.val[31:0];
          default: ;
        endcase
      end
      default: ;
    endcase
    row_after = row_n;
    if (emit) begin
      if (cur.kind == CMD_EXT) begin
        row_after = init_row;
      end else begin
        row_after.block_start   = 1'b0;
        row_after.pro_end       = 1'b0;
        row_after.epi_start     = 1'b0;
        row_after.discriminator = '0;
      end
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (!q_empty) state_next = needs_div ? B_DIV : (needs_mul ? B_MUL : B_EXEC);
      end
      B_DIV:  if (div_cnt == 3'd7) state_next = B_MUL;
      B_MUL:  state_next = B_EXEC;
      B_EXEC: if (!emit || can_emit) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
      row       <= init_row;
    end else begin
      state <= state_next;
      if (state == B_IDLE && !q_empty && q_cmd.init) row <= init_row;
      if (state == B_EXEC && (!emit || can_emit)) row <= row_after;
      if (state == B_EXEC && emit && can_emit) out_valid <= 1'b1;
      else if (out_pop) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_IDLE && !q_empty) begin
      cur     <= q_cmd;
      div_r   <= '0;
      div_q   <= (q_cmd.kind == CMD_SPECIAL) ? q_cmd.val[7:0]
                                            : SPECIAL_LIMIT - {3'b0, cfg.opcode_base};
      div_cnt <= '0;
    end
    if (state == B_DIV) begin
      div_r   <= div_r_n;
      div_q   <= div_q_n;
      div_cnt <= div_cnt + 3'd1;
    end
    if (state == B_MUL) prod <= mprod[63:0];
    if (state == B_EXEC && emit && can_emit) out_row <= row_n;
  end

endmodule

[rtl/line_number_program_interpreter_unit.sv]
// Top level of the line-number program interpreter: configuration registers,
// byte parser, command queue and row engine. Depends on lnpi_pkg and the lnpi_* modules.
//
//   channel   direction  handshake               payload
//   bytes     in         push / full             data_byte, new_program
//   rows      out        empty / pop             row_* (11 fields)
//   config    in         wr_en (no back-pressure) wr_index, wr_data
//
// The parser takes one byte per cycle while the command queue has room.
// A row engine command passes the pop and execute states; a special opcode or
// const_add_pc also passes the 8-step serial divider by line_range and then the
// address multiply, and advance_pc passes the address multiply alone.
// Reset (rst, synchronous) loads the configuration defaults, clears parser and
// queue state, loads the row registers with initial values and clears out_valid.
// Stalls: full rises when the command queue is full; the engine holds a row
// until the output register is free, so pop back-pressure reaches the input.
module line_number_program_interpreter_unit #(
  parameter int TABLE_ENTRIES = lnpi_pkg::DEF_TABLE_ENTRIES,
  parameter int COUNT_BITS    = lnpi_pkg::DEF_COUNT_BITS,
  parameter int ADDRESS_BYTES = lnpi_pkg::DEF_ADDRESS_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  // byte transactions
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte,
  input  logic        new_program,
  // row transactions
  output logic        empty,
  input  logic        pop,
  output logic [63:0] row_address,
  output logic [31:0] row_file,
  output logic [31:0] row_line,
  output logic [31:0] row_column,
  output logic        row_is_stmt,
  output logic        row_basic_block,
  output logic        row_end_sequence,
  output logic        row_prologue_end,
  output logic        row_epilogue_begin,
  output logic [31:0] row_isa,
  output logic [31:0] row_discriminator,
  // configuration writes
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [63:0] wr_data
);
  import lnpi_pkg::*;

  cfg_t cfg;
  cmd_t f_cmd, q_cmd;
  row_t out_row;
  logic take, f_valid, q_empty, q_full, q_pop, out_valid, out_pop;

  // Hold a byte back while the queue has no room for its command
  assign full    = q_full;
  assign take    = push && !q_full;
  assign empty   = !out_valid;
  assign out_pop = pop && out_valid;

  assign row_address        = out_row.address;
  assign row_file           = out_row.file;
  assign row_line           = out_row.line;
  assign row_column         = out_row.column;
  assign row_is_stmt        = out_row.is_stmt;
  assign row_basic_block    = out_row.block_start;
  assign row_end_sequence   = out_row.seq_end;
  assign row_prologue_end   = out_row.pro_end;
  assign row_epilogue_begin = out_row.epi_start;
  assign row_isa            = out_row.isa;
  assign row_discriminator  = out_row.discriminator;

  // Configuration registers; writes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.opcode_base     <= RST_OPCODE_BASE;
      cfg.line_floor      <= RST_LINE_BASE;
      cfg.line_span       <= RST_LINE_RANGE;
      cfg.min_inst_length <= RST_MIN_INST_LENGTH;
      cfg.stmt_init       <= RST_DEFAULT_IS_STMT;
      cfg.arg_count_table <= RST_ARG_COUNT_TABLE;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_OPCODE_BASE:     cfg.opcode_base     <= wr_data[4:0];
        REG_LINE_BASE:       cfg.line_floor      <= wr_data[7:0];
        REG_LINE_RANGE:      cfg.line_span       <= wr_data[7:0];
        REG_MIN_INST_LENGTH: cfg.min_inst_length <= wr_data[7:0];
        REG_DEFAULT_IS_STMT: cfg.stmt_init       <= wr_data[0];
        REG_ARG_COUNT_TABLE: cfg.arg_count_table <= wr_data;
        default: ;
      endcase
    end
  end

  lnpi_front #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .COUNT_BITS    (COUNT_BITS),
    .ADDRESS_BYTES (ADDRESS_BYTES)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .data_byte   (data_byte),
    .new_program (new_program),
    .cfg         (cfg),
    .cmd_valid   (f_valid),
    .cmd         (f_cmd)
  );

  lnpi_cmd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_cmd   (f_cmd),
    .rd_en    (q_pop),
    .rd_cmd   (q_cmd),
    .empty    (q_empty),
    .full     (q_full)
  );

  lnpi_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_row   (out_row),
    .out_valid (out_valid),
    .out_pop   (out_pop)
  );

endmodule
